// ===== sv/rwfs_pkg.sv =====
package rwfs_pkg;

   localparam int SAMPLE_W = 16;
   localparam int STAMP_W = 17;
   localparam int CH_W = 3;
   localparam int TOTAL_W = 24;
   localparam int SQ_W = 40;
   localparam int VAR_W = 32;
   localparam int COV_W = 31;
   localparam int CFG_W = 8;
   localparam logic [CFG_W-1:0] WINDOW_RESET = 8'd120;

   localparam logic OP_W = 1'b0;
   localparam logic OP_X = 1'b1;

   typedef struct packed {
      logic start;
      logic div_start;
      logic [1:0] div_sel;
      logic commit;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic clearing;
      logic div_done;
   } ctl_sts_type;

endpackage

// ===== sv/rwfs_div.sv =====
module rwfs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [40:0] dividend,
   input  logic [12:0] divisor,
   output logic        done,
   output logic [40:0] quotient
);
   logic [40:0] quo_ff, quo_in;
   logic [13:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        neg_ff, neg_in;
   logic        done_ff, done_in;
   logic [13:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      trial = {rem_ff[12:0], quo_ff[40]};
      if (start) begin
         neg_in = dividend[40];
         quo_in = dividend[40] ? 41'(-dividend) : dividend;
         rem_in = '0;
         cnt_in = 6'd41;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            quo_in = {quo_ff[39:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[39:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = neg_ff ? 41'(-quo_ff) : quo_ff;
endmodule

// ===== sv/rwfs_ctrl.sv =====
module rwfs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rwfs_pkg::ctl_cmd_type cmd,
   input  rwfs_pkg::ctl_sts_type sts
);
   import rwfs_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_UPD  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE) || sts.clearing;
   assign accept = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      cmd = '0;
      cmd.div_sel = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.start = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_UPD;
         ST_UPD: begin
            cmd.commit = 1'b1;
            sel_in = 2'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (sts.div_done) begin
               if (sel_ff == 2'd2) begin
                  cmd.finish = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  sel_in = sel_ff + 2'd1;
                  state_in = ST_DIV;
               end
            end
         end
         ST_OUT: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept during result");
   a_one_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid) else $error("finish lost");
endmodule

// ===== sv/rwfs_data.sv =====
module rwfs_data #(
   parameter int WINDOW_MAX = 128,
   parameter int CHANNELS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rwfs_pkg::CFG_W-1:0]    window_length,
   input  rwfs_pkg::ctl_cmd_type         cmd,
   output rwfs_pkg::ctl_sts_type         sts,
   input  logic                          req_opcode,
   input  logic [rwfs_pkg::CH_W-1:0]     req_channel,
   input  logic [rwfs_pkg::STAMP_W-1:0]  req_second_stamp,
   input  logic signed [15:0]            req_w_value,
   input  logic signed [15:0]            req_x_value,
   output logic [rwfs_pkg::VAR_W-1:0]    rsp_variance,
   output logic signed [rwfs_pkg::COV_W-1:0] rsp_covariance
);
   import rwfs_pkg::*;

   localparam int PW = $clog2(WINDOW_MAX);
   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int NW = PW + 1;
   localparam int SW = CW + PW;

   logic signed [15:0] w_ring [WINDOW_MAX];
   logic signed [15:0] x_ring [CHANNELS*WINDOW_MAX];
   logic [SW-1:0] clr_ff;
   logic clr_busy_ff;
   logic signed [TOTAL_W-1:0] xt_ff [CHANNELS];
   logic signed [SQ_W-1:0] xs_ff [CHANNELS];
   logic signed [SQ_W-1:0] cr_ff [CHANNELS];
   logic signed [TOTAL_W-1:0] wt_ff;
   logic signed [SQ_W-1:0] ws_ff;
   logic [PW-1:0] wpos_ff, xpos_ff;
   logic [STAMP_W-1:0] stamp_ff;
   logic seen_ff;
   logic signed [15:0] evw_ff, wmean_ff;

   logic op_ff, skip_ff;
   logic [CW-1:0] ch_ff;
   logic [STAMP_W-1:0] stp_ff;
   logic signed [15:0] w_ff, x_ff, oldr_ff;
   logic [PW-1:0] pos_ff;
   logic [SW-1:0] slot_ff;
   logic advx_ff;
   logic signed [TOTAL_W-1:0] tot_ff;
   logic signed [SQ_W-1:0] sq_ff, crs_ff;
   logic signed [15:0] mean_ff;
   logic signed [40:0] q_sq_ff;
   logic [VAR_W-1:0] var_ff;
   logic signed [COV_W-1:0] cov_ff;

   logic [NW-1:0] n;
   logic [PW:0] wadv, xadv;
   logic [PW-1:0] wnext, xnext;
   logic adv_now;
   logic [PW-1:0] xsel;
   logic div_done;
   logic [40:0] div_a;
   logic [40:0] quo;
   logic signed [40:0] qs;
   logic signed [15:0] oldv;
   logic signed [TOTAL_W-1:0] tot_n;
   logic signed [SQ_W-1:0] sq_n, cr_n;
   logic signed [15:0] mean_sat;
   logic signed [42:0] var_full, cov_full;

   always_comb begin
      if (window_length == '0) n = NW'(1);
      else if (int'(window_length) > WINDOW_MAX) n = NW'(WINDOW_MAX);
      else n = NW'(window_length);
      wadv = {1'b0, wpos_ff} + 1'b1;
      xadv = {1'b0, xpos_ff} + 1'b1;
      wnext = (wadv >= (PW+1)'(n)) ? '0 : wadv[PW-1:0];
      xnext = (xadv >= (PW+1)'(n)) ? '0 : xadv[PW-1:0];
      adv_now = !seen_ff || (req_second_stamp != stamp_ff);
      xsel = adv_now ? xnext : xpos_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff <= req_opcode;
         w_ff <= req_w_value;
         x_ff <= req_x_value;
         ch_ff <= CW'(req_channel);
         stp_ff <= req_second_stamp;
         skip_ff <= (req_opcode == OP_X) && (int'(req_channel) >= CHANNELS);
         advx_ff <= adv_now;
         if (req_opcode == OP_W) begin
            pos_ff <= wnext;
            oldr_ff <= w_ring[wnext];
         end else begin
            pos_ff <= xsel;
            slot_ff <= {CW'(req_channel), xsel};
            oldr_ff <= x_ring[{CW'(req_channel), xsel}];
         end
      end
      if (clr_busy_ff) begin
         w_ring[clr_ff[PW-1:0]] <= '0;
         x_ring[clr_ff] <= '0;
      end else if (cmd.commit && !skip_ff) begin
         if (op_ff == OP_W) w_ring[pos_ff] <= w_ff;
         else x_ring[slot_ff] <= x_ff;
      end
   end

   assign oldv = oldr_ff;

   always_comb begin
      if (op_ff == OP_W) begin
         tot_n = wt_ff - TOTAL_W'(oldv) + TOTAL_W'(w_ff);
         sq_n = ws_ff - SQ_W'(oldv * oldv) + SQ_W'(w_ff * w_ff);
         cr_n = '0;
      end else begin
         tot_n = xt_ff[ch_ff] - TOTAL_W'(oldv) + TOTAL_W'(x_ff);
         sq_n = xs_ff[ch_ff] - SQ_W'(oldv * oldv) + SQ_W'(x_ff * x_ff);
         cr_n = cr_ff[ch_ff] - SQ_W'(evw_ff * oldv) + SQ_W'(w_ff * x_ff);
      end
   end

   always_comb begin
      case (cmd.div_sel)
         2'd0: div_a = 41'(tot_ff);
         2'd1: div_a = 41'(sq_ff);
         default: div_a = 41'(crs_ff);
      endcase
   end

   rwfs_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(div_a), .divisor(13'(n)), .done(div_done), .quotient(quo)
   );

   assign sts = '{clearing: clr_busy_ff, div_done: div_done};

   assign qs = signed'(quo);
   assign mean_sat = (qs > 41'sd32767) ? 16'sd32767 :
                     (qs < -41'sd32768) ? -16'sd32768 : qs[15:0];
   assign var_full = 43'(q_sq_ff) - 43'(mean_ff * mean_ff);
   assign cov_full = 43'(qs) - 43'(wmean_ff * mean_ff);

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         tot_ff <= tot_n;
         sq_ff <= sq_n;
         crs_ff <= cr_n;
      end
      if (div_done) begin
         case (cmd.div_sel)
            2'd0: mean_ff <= mean_sat;
            2'd1: q_sq_ff <= qs;
            default: ;
         endcase
      end
      if (cmd.finish) begin
         if (skip_ff) begin
            var_ff <= '0;
            cov_ff <= '0;
         end else begin
            if (var_full < 0) var_ff <= '0;
            else if (var_full > 43'sd4294967295) var_ff <= '1;
            else var_ff <= var_full[31:0];
            if (op_ff == OP_W) cov_ff <= '0;
            else if (cov_full > 43'sd1073741823) cov_ff <= 31'sd1073741823;
            else if (cov_full < -43'sd1073741824) cov_ff <= -31'sd1073741824;
            else cov_ff <= cov_full[30:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         clr_busy_ff <= 1'b1;
         wt_ff <= '0;
         ws_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            xt_ff[i] <= '0;
            xs_ff[i] <= '0;
            cr_ff[i] <= '0;
         end
         wpos_ff <= '0;
         xpos_ff <= '0;
         stamp_ff <= '0;
         seen_ff <= 1'b0;
         evw_ff <= '0;
         wmean_ff <= '0;
      end else begin
         if (clr_busy_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == SW'(CHANNELS*WINDOW_MAX-1)) clr_busy_ff <= 1'b0;
         end
         if (cmd.commit && !skip_ff) begin
            if (op_ff == OP_W) begin
               wt_ff <= tot_n;
               ws_ff <= sq_n;
               wpos_ff <= pos_ff;
               evw_ff <= oldv;
            end else begin
               xt_ff[ch_ff] <= tot_n;
               xs_ff[ch_ff] <= sq_n;
               cr_ff[ch_ff] <= cr_n;
               if (advx_ff) begin
                  xpos_ff <= pos_ff;
                  stamp_ff <= stp_ff;
                  seen_ff <= 1'b1;
               end
            end
         end
         if (cmd.finish && op_ff == OP_W) wmean_ff <= mean_ff;
      end
   end

   assign rsp_variance = var_ff;
   assign rsp_covariance = cov_ff;
endmodule

// ===== sv/running_window_flux_statistics.sv =====
// Channel | Direction | Handshake         | Payload
// req     | in        | req_valid/stall   | opcode, channel, second_stamp, w_value, x_value
// rsp     | out       | rsp_valid/stall   | variance, covariance
// csr     | in        | csr_valid/ready   | window_length
// One item at a time; rsp_valid rises with the registered result after the third divider pass.
// A new item is accepted only after the previous result has been transferred.
// Each item takes three passes of the shared 41-step serial divider: sum, squares, cross sum.
// Synchronous reset clears sums and positions, then the rings are cleared one entry per
// cycle, CHANNELS*WINDOW_MAX entries (1024 by default), while the input is stalled.
// The input stays stalled from acceptance until the result is transferred.
module running_window_flux_statistics #(
   parameter int WINDOW_MAX = 128,
   parameter int CHANNELS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [rwfs_pkg::CH_W-1:0]     req_channel,
   input  logic [rwfs_pkg::STAMP_W-1:0]  req_second_stamp,
   input  logic signed [15:0]            req_w_value,
   input  logic signed [15:0]            req_x_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rwfs_pkg::VAR_W-1:0]    rsp_variance,
   output logic signed [rwfs_pkg::COV_W-1:0] rsp_covariance,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rwfs_pkg::CFG_W-1:0]    csr_window_length
);
   import rwfs_pkg::*;

   logic [CFG_W-1:0] wlen_ff;
   ctl_cmd_type cmd;
   ctl_sts_type sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) wlen_ff <= WINDOW_RESET;
      else if (csr_valid) wlen_ff <= csr_window_length;
   end

   rwfs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .cmd(cmd), .sts(sts)
   );

   rwfs_data #(.WINDOW_MAX(WINDOW_MAX), .CHANNELS(CHANNELS)) u_data (
      .clock(clock), .reset(reset), .window_length(wlen_ff), .cmd(cmd), .sts(sts),
      .req_opcode(req_opcode), .req_channel(req_channel),
      .req_second_stamp(req_second_stamp), .req_w_value(req_w_value),
      .req_x_value(req_x_value), .rsp_variance(rsp_variance),
      .rsp_covariance(rsp_covariance)
   );
endmodule
